// File: hdl/keyed_decimal_field_extractor_macros.svh
// Assertion macros used by the bound checker in kdfe_checker.sv.
`ifndef KEYED_DECIMAL_FIELD_EXTRACTOR_MACROS_SVH
`define KEYED_DECIMAL_FIELD_EXTRACTOR_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define KDFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define KDFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kdfe_pkg.sv
package kdfe_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] data_t;

	localparam logic [ADDR_W-3:0] REG_CHANNEL_LIMIT = '0;
	localparam logic [7:0] LIMIT_RESET = 8'd255;

	localparam logic [1:0] STATUS_ABSENT  = 2'd0;
	localparam logic [1:0] STATUS_VALID   = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [3:0] KEY_LEN = 4'd8;

	typedef enum logic [2:0] {
		CLS_NUL,
		CLS_SEMI,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_OTHER
	} kdfe_class_t;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        end_of_command;
		kdfe_class_t cls;
		logic [3:0]  digit;
	} kdfe_item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} kdfe_q_stat_t;

	// Characters of the key "CHANNEL=".
	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h43;
			3'd1: c = 8'h48;
			3'd2: c = 8'h41;
			3'd3: c = 8'h4E;
			3'd4: c = 8'h4E;
			3'd5: c = 8'h45;
			3'd6: c = 8'h4C;
			3'd7: c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/kdfe_if.sv
interface kdfe_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_command;

	modport source (output valid, output text_byte, output end_of_command, input ready);
	modport sink (input valid, input text_byte, input end_of_command, output ready);
endinterface

interface kdfe_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] field_status;
	logic [7:0] channel_value;

	modport source (output valid, output field_status, output channel_value, input ready);
	modport sink (input valid, input field_status, input channel_value, output ready);
endinterface

// File: hdl/kdfe_front.sv
module kdfe_front (
	kdfe_cmd_if.sink            cmd,
	input  kdfe_pkg::kdfe_q_stat_t q_stat,
	output logic                push,
	output kdfe_pkg::kdfe_item_t item
);
	import kdfe_pkg::*;

	assign cmd.ready = !q_stat.full;
	assign push = cmd.valid && !q_stat.full;

	always_comb begin
		item.text_byte = cmd.text_byte;
		item.end_of_command = cmd.end_of_command;
		item.digit = 4'(cmd.text_byte - CHAR_ZERO);
		if (cmd.text_byte == 8'h00) begin
			item.cls = CLS_NUL;
		end else if (cmd.text_byte == CHAR_SEMI) begin
			item.cls = CLS_SEMI;
		end else if (cmd.text_byte == CHAR_MINUS) begin
			item.cls = CLS_MINUS;
		end else if (cmd.text_byte >= CHAR_ZERO && cmd.text_byte <= CHAR_NINE) begin
			item.cls = CLS_DIGIT;
		end else begin
			item.cls = CLS_OTHER;
		end
	end
endmodule

// File: hdl/kdfe_queue.sv
module kdfe_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  kdfe_pkg::kdfe_item_t   wr_item,
	input  logic                   pop,
	output kdfe_pkg::kdfe_item_t   rd_item,
	output kdfe_pkg::kdfe_q_stat_t q_stat
);
	import kdfe_pkg::*;

	kdfe_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rd_item = entry_q[rd_ptr_q];
	assign q_stat.valid = (count_q != 2'd0);
	assign q_stat.full = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

// File: hdl/kdfe_back.sv
module kdfe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             channel_limit,
	input  kdfe_pkg::kdfe_q_stat_t q_stat,
	input  kdfe_pkg::kdfe_item_t   item,
	output logic                   pop,
	kdfe_res_if.source             res
);
	import kdfe_pkg::*;

	typedef enum logic [1:0] {
		MODE_MATCH,
		MODE_SKIP,
		MODE_VALUE,
		MODE_DONE
	} mode_t;

	typedef struct packed {
		logic [3:0] key_pos;
		mode_t      mode;
		logic [8:0] acc;
		logic       minus;
		logic       digit;
		logic       bad;
		logic [1:0] status;
		logic [7:0] channel;
	} scan_t;

	localparam scan_t SCAN_CLEAR = '{
		key_pos: 4'd0, mode: MODE_MATCH, acc: 9'd0, minus: 1'b0, digit: 1'b0,
		bad: 1'b0, status: STATUS_ABSENT, channel: 8'd0
	};

	scan_t      scan_q;
	scan_t      scan_d;
	scan_t      fin;
	logic       res_valid_q;
	logic [1:0] res_status_q;
	logic [7:0] res_channel_q;
	logic [8:0] cap;
	logic [11:0] prod;

	function automatic scan_t finish(input scan_t s, input logic [7:0] lim);
		scan_t r;
		logic  ok;
		r = s;
		ok = !s.bad && s.digit;
		if (ok) begin
			ok = s.minus ? (s.acc == 9'd0) : (s.acc <= {1'b0, lim});
		end
		r.status = ok ? STATUS_VALID : STATUS_INVALID;
		r.channel = ok ? s.acc[7:0] : 8'd0;
		r.mode = MODE_DONE;
		return r;
	endfunction

	assign pop = q_stat.valid && (!item.end_of_command || !res_valid_q || res.ready);
	assign cap = {1'b0, channel_limit} + 9'd1;
	assign prod = {3'b0, scan_q.acc} * 12'd10 + {8'b0, item.digit};

	always_comb begin
		scan_d = scan_q;
		if (scan_q.mode != MODE_DONE) begin
			if (item.cls == CLS_NUL) begin
				if (scan_q.mode == MODE_VALUE) begin
					scan_d = finish(scan_q, channel_limit);
				end
				scan_d.mode = MODE_DONE;
			end else if (scan_q.mode == MODE_VALUE) begin
				case (item.cls)
					CLS_SEMI: scan_d = finish(scan_q, channel_limit);
					CLS_MINUS: begin
						if (!scan_q.minus && !scan_q.digit && !scan_q.bad) begin
							scan_d.minus = 1'b1;
						end else begin
							scan_d.bad = 1'b1;
						end
					end
					CLS_DIGIT: begin
						scan_d.digit = 1'b1;
						scan_d.acc = (prod > {3'b0, cap}) ? cap : prod[8:0];
					end
					default: scan_d.bad = 1'b1;
				endcase
			end else if (item.cls == CLS_SEMI) begin
				scan_d.key_pos = 4'd0;
				scan_d.mode = MODE_MATCH;
			end else if (scan_q.mode == MODE_MATCH) begin
				if (scan_q.key_pos < KEY_LEN
						&& item.text_byte == key_char(scan_q.key_pos[2:0])) begin
					scan_d.key_pos = scan_q.key_pos + 4'd1;
					if (scan_d.key_pos >= KEY_LEN) begin
						scan_d.mode = MODE_VALUE;
						scan_d.acc = 9'd0;
						scan_d.minus = 1'b0;
						scan_d.digit = 1'b0;
						scan_d.bad = 1'b0;
					end
				end else begin
					scan_d.mode = MODE_SKIP;
				end
			end
		end
		fin = (scan_d.mode == MODE_VALUE) ? finish(scan_d, channel_limit) : scan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SCAN_CLEAR;
			res_valid_q <= 1'b0;
			res_status_q <= STATUS_ABSENT;
			res_channel_q <= 8'd0;
		end else begin
			if (pop) begin
				scan_q <= item.end_of_command ? SCAN_CLEAR : scan_d;
			end
			if (pop && item.end_of_command) begin
				res_valid_q <= 1'b1;
				res_status_q <= fin.status;
				res_channel_q <= fin.channel;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid = res_valid_q;
	assign res.field_status = res_status_q;
	assign res.channel_value = res_channel_q;
endmodule

// File: hdl/keyed_decimal_field_extractor.sv
// Channel   Direction  Beat contents
// cmd       sink       text_byte (8), end_of_command (1)
// res       source     field_status (2), channel_value (8)
// APB       slave      channel_limit at byte address 0
//
// The block takes one command byte per cycle, sustained, while results drain.
// A byte is written into the two-entry queue when it is accepted and is then
// scanned from the queue; with no stall ahead, the last byte of a command loads the result register.
// arst_n clears the scan state, the queue and the result register, and sets
// channel_limit to 255; no clearing pass is needed.
// A stalled result holds back only the last byte of the next command, and the
// queue keeps taking bytes until both of its entries are filled.
module keyed_decimal_field_extractor (
	input  logic            clk,
	input  logic            arst_n,
	kdfe_cmd_if.sink        cmd,
	kdfe_res_if.source      res,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  kdfe_pkg::addr_t paddr,
	input  kdfe_pkg::data_t pwdata,
	output kdfe_pkg::data_t prdata,
	output logic            pready
);
	import kdfe_pkg::*;

	// The single configuration register. Writes to any other register
	// index are dropped, and reads of such an index return zero.
	logic [7:0]   channel_limit_q;
	logic         reg_hit;

	// Front to queue and queue to back.
	logic         push;
	logic         pop;
	kdfe_item_t   wr_item;
	kdfe_item_t   rd_item;
	kdfe_q_stat_t q_stat;

	assign pready = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_CHANNEL_LIMIT);
	assign prdata = reg_hit ? {{(DATA_W-8){1'b0}}, channel_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			channel_limit_q <= pwdata[7:0];
		end
	end

	// The front classifies each byte as it is accepted, so the scan stage
	// only has to follow the key match and the value accumulation.
	kdfe_front u_front (
		.cmd    (cmd),
		.q_stat (q_stat),
		.push   (push),
		.item   (wr_item)
	);

	kdfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.q_stat  (q_stat)
	);

	// The back end scans bytes in order and loads the result register on
	// the last byte of each command.
	kdfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_limit (channel_limit_q),
		.q_stat        (q_stat),
		.item          (rd_item),
		.pop           (pop),
		.res           (res)
	);
endmodule

// File: hdl/kdfe_checker.sv
`include "keyed_decimal_field_extractor_macros.svh"

module kdfe_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [1:0]           field_status,
	input logic [7:0]           channel_value,
	input kdfe_pkg::data_t      prdata,
	input logic                 pready
);
	import kdfe_pkg::*;

	`KDFE_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable({field_status, channel_value}), "result changed while stalled")
	`KDFE_ASSERT(a_status_code, clk, arst_n, res_valid |-> (field_status == STATUS_ABSENT || field_status == STATUS_VALID || field_status == STATUS_INVALID), "undefined status code")
	`KDFE_ASSERT(a_channel_zero, clk, arst_n, res_valid && field_status != STATUS_VALID |-> channel_value == 8'd0, "channel set without a valid status")
	`KDFE_ASSERT(a_prdata_narrow, clk, arst_n, prdata[DATA_W-1:8] == '0, "read data above the register width")
	`KDFE_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")
endmodule

bind keyed_decimal_field_extractor kdfe_checker u_kdfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.field_status  (res.field_status),
	.channel_value (res.channel_value),
	.prdata        (prdata),
	.pready        (pready)
);

// File: tb/keyed_decimal_field_extractor_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register channels, keeps its own copy of
// the field scan, and compares every result beat with the oldest report due.
module keyed_decimal_field_extractor_checker (
	input  logic            clk,
	input  logic            arst_n,
	kdfe_cmd_if             cmd,
	kdfe_res_if             res,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  kdfe_pkg::addr_t paddr,
	input  kdfe_pkg::data_t pwdata,
	input  kdfe_pkg::data_t prdata,
	input  logic            pready,
	output int              mismatches,
	output int              outstanding,
	output int              absent_seen,
	output int              valid_seen,
	output int              invalid_seen
);
	import kdfe_pkg::*;

	localparam logic [63:0] KEY_CHARS = "CHANNEL=";
	localparam logic [7:0]  CHAR_NUL  = 8'h00;

	typedef enum logic [1:0] {
		SCAN_MATCH,
		SCAN_SKIP,
		SCAN_VALUE,
		SCAN_DONE
	} scan_mode_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] channel;
	} channel_report_t;

	channel_report_t channel_reports_due[$];

	logic [7:0] channel_limit;
	logic [3:0] key_pos;
	scan_mode_t scan_mode;
	logic [8:0] value_acc;
	logic       minus_seen;
	logic       digit_seen;
	logic       value_bad;
	logic [1:0] held_status;
	logic [7:0] held_channel;
	int         fail_count;
	int         n_absent;
	int         n_valid;
	int         n_invalid;

	function automatic void restart_command();
		key_pos      = '0;
		scan_mode    = SCAN_MATCH;
		value_acc    = '0;
		minus_seen   = 1'b0;
		digit_seen   = 1'b0;
		value_bad    = 1'b0;
		held_status  = STATUS_ABSENT;
		held_channel = '0;
	endfunction

	// Closes the value of the keyed segment and fixes the report.
	function automatic void settle_channel_value();
		logic ok;
		ok = !value_bad && digit_seen;
		if (ok) begin
			ok = minus_seen ? (value_acc == 9'd0) : (value_acc <= {1'b0, channel_limit});
		end
		held_status  = ok ? STATUS_VALID : STATUS_INVALID;
		held_channel = ok ? value_acc[7:0] : 8'd0;
		scan_mode    = SCAN_DONE;
	endfunction

	function automatic void scan_command_byte(input logic [7:0] b);
		int grown;
		if (scan_mode == SCAN_DONE) begin
			return;
		end
		if (b == CHAR_NUL) begin
			if (scan_mode == SCAN_VALUE) begin
				settle_channel_value();
			end
			scan_mode = SCAN_DONE;
			return;
		end
		if (scan_mode == SCAN_VALUE) begin
			if (b == CHAR_SEMI) begin
				settle_channel_value();
			end else if (b == CHAR_MINUS && !minus_seen && !digit_seen && !value_bad) begin
				minus_seen = 1'b1;
			end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				digit_seen = 1'b1;
				grown = int'(value_acc) * 10 + int'(b - CHAR_ZERO);
				if (grown > int'(channel_limit) + 1) begin
					grown = int'(channel_limit) + 1;
				end
				value_acc = grown[8:0];
			end else begin
				value_bad = 1'b1;
			end
			return;
		end
		if (b == CHAR_SEMI) begin
			key_pos   = '0;
			scan_mode = SCAN_MATCH;
			return;
		end
		if (scan_mode == SCAN_MATCH) begin
			if (key_pos < KEY_LEN && b == KEY_CHARS[8 * (7 - int'(key_pos)) +: 8]) begin
				key_pos = key_pos + 4'd1;
				if (key_pos >= KEY_LEN) begin
					scan_mode  = SCAN_VALUE;
					value_acc  = '0;
					minus_seen = 1'b0;
					digit_seen = 1'b0;
					value_bad  = 1'b0;
				end
			end else begin
				scan_mode = SCAN_SKIP;
			end
		end
	endfunction

	function automatic void take_command_byte(input logic [7:0] b, input logic last);
		channel_report_t rpt;
		scan_command_byte(b);
		if (last) begin
			if (scan_mode == SCAN_VALUE) begin
				settle_channel_value();
			end
			rpt.status  = held_status;
			rpt.channel = held_channel;
			channel_reports_due.push_back(rpt);
			restart_command();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		channel_report_t want;
		if (!arst_n) begin
			channel_limit = LIMIT_RESET;
			restart_command();
			channel_reports_due.delete();
			outstanding <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				take_command_byte(cmd.text_byte, cmd.end_of_command);
			end
			if (res.valid && res.ready) begin
				if (channel_reports_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with no report due: status %0d channel %0d",
						$time, res.field_status, res.channel_value);
				end else begin
					want = channel_reports_due.pop_front();
					case (want.status)
						STATUS_VALID:   n_valid++;
						STATUS_INVALID: n_invalid++;
						default:        n_absent++;
					endcase
					if (res.field_status !== want.status) begin
						fail_count++;
						$display("%0t: field_status expected %0d, actual %0d",
							$time, want.status, res.field_status);
					end
					if (res.channel_value !== want.channel) begin
						fail_count++;
						$display("%0t: channel_value expected %0d, actual %0d",
							$time, want.channel, res.channel_value);
					end
				end
			end
			if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_CHANNEL_LIMIT) begin
				if (pwrite) begin
					channel_limit = pwdata[7:0];
				end else if (prdata !== data_t'(channel_limit)) begin
					fail_count++;
					$display("%0t: channel_limit read expected %0d, actual %0d",
						$time, channel_limit, prdata);
				end
			end
			outstanding <= channel_reports_due.size();
		end
		mismatches   <= fail_count;
		absent_seen  <= n_absent;
		valid_seen   <= n_valid;
		invalid_seen <= n_invalid;
	end

endmodule

// File: tb/keyed_decimal_field_extractor_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the keyed decimal field extractor. The checker
// beside the block does all prediction and comparison; this module only
// builds commands, drives the channels and the register port, and decides.
module keyed_decimal_field_extractor_tb;
	import kdfe_pkg::*;

	// Byte address of a register is its index times four.
	localparam logic [ADDR_W-3:0] REG_UNMAPPED = 1'b1;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	// A byte passes from the queue into the scan state once it is accepted, so
	// the settle period covers a partial command still in the queue.
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_BYTES    = 1424;
	localparam int RANDOM_PHASES   = 8;
	localparam int PRESSURE_PHASE  = 2;

	logic  clk;
	logic  arst_n;
	logic  psel;
	logic  penable;
	logic  pwrite;
	addr_t paddr;
	data_t pwdata;
	data_t prdata;
	logic  pready;

	kdfe_cmd_if cmd_ch ();
	kdfe_res_if res_ch ();

	int mismatches;
	int outstanding;
	int absent_seen;
	int valid_seen;
	int invalid_seen;

	// Sender state: the bytes of the command under construction, the length
	// left in the current burst, and whether gaps are switched off.
	logic [7:0] command_text[$];
	int         burst_left;
	bit         steady_sender;
	int         bytes_sent;
	int         commands_sent;
	int         limit_settings;
	int         cur_limit;

	// The receiver serves one long stall per request that it has not yet
	// served; the stimulus raises the request count.
	int holdoff_requests;
	int holdoffs_done;

	keyed_decimal_field_extractor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	keyed_decimal_field_extractor_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.res          (res_ch),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.absent_seen  (absent_seen),
		.valid_seen   (valid_seen),
		.invalid_seen (invalid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one beat and returns at the edge where it is taken. Bursts of
	// random length are separated by random gaps; some bursts have no gap
	// at all so that back-to-back streaming is covered too.
	task automatic offer_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 7))
				0, 1:    gap = 0;
				7:       gap = $urandom_range(10, 24);
				default: gap = $urandom_range(1, 5);
			endcase
			if (steady_sender) begin
				gap = 0;
			end
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid          <= 1'b1;
		cmd_ch.text_byte      <= b;
		cmd_ch.end_of_command <= last;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		bytes_sent++;
	endtask

	// Sends the collected bytes; with close set, the final one ends the
	// command and so produces a result.
	task automatic send_text(input bit close);
		for (int i = 0; i < command_text.size(); i++) begin
			offer_byte(command_text[i], close && (i == command_text.size() - 1));
		end
		if (close) begin
			commands_sent++;
		end
		command_text.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			command_text.push_back(s[i]);
		end
	endtask

	task automatic send_command(input string s);
		add_text(s);
		send_text(1'b1);
	endtask

	// Lets every expected result arrive, then waits out the settle period so that a
	// partial command has left the queue before the register changes.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [ADDR_W-3:0] idx, input data_t data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes the limit and reads it back; the checker compares the read.
	// Upper bits of the word are random and must be dropped by the block.
	task automatic set_channel_limit(input logic [7:0] lim);
		apb_access(1'b1, REG_CHANNEL_LIMIT, {24'($urandom_range(0, 32'h00FF_FFFF)), lim});
		apb_access(1'b0, REG_CHANNEL_LIMIT, '0);
		cur_limit = lim;
		limit_settings++;
	endtask

	// Channel numbers cluster at the edges of the current limit.
	function automatic int pick_channel_number(input int lim);
		case ($urandom_range(0, 6))
			0:       return 0;
			1:       return lim;
			2:       return lim + 1;
			3:       return $urandom_range(0, lim);
			4:       return $urandom_range(0, 300);
			5:       return $urandom_range(0, 99999);
			default: return $urandom_range(0, 9);
		endcase
	endfunction

	// One random command: mostly keyed segments with well-formed values and
	// random content, mixed with broken values, partial keys, other fields,
	// raw noise bytes, stray separators and early zero terminators.
	task automatic build_random_command();
		string key_word;
		int    segs;
		int    n;
		key_word = "CHANNEL=";
		segs = $urandom_range(1, 4);
		for (int s = 0; s < segs; s++) begin
			if (s > 0) begin
				command_text.push_back(CHAR_SEMI);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					add_text(key_word);
					if ($urandom_range(0, 7) == 0) begin
						command_text.push_back(CHAR_MINUS);
					end
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
					repeat (n) command_text.push_back(CHAR_ZERO);
					add_text($sformatf("%0d", pick_channel_number(cur_limit)));
				end
				4, 5: begin
					add_text(key_word);
					case ($urandom_range(0, 5))
						0: ;
						1: command_text.push_back(CHAR_MINUS);
						2: add_text("12-3");
						3: begin
							add_text($sformatf("%0d", $urandom_range(0, 300)));
							command_text.push_back(8'($urandom_range(65, 90)));
						end
						4: add_text("--7");
						default: begin
							add_text($sformatf("%0d", $urandom_range(0, 9)));
							command_text.push_back(8'($urandom_range(1, 255)));
						end
					endcase
				end
				6: begin
					n = $urandom_range(0, 7);
					for (int i = 0; i < n; i++) begin
						command_text.push_back(key_word[i]);
					end
					if ($urandom_range(0, 1) == 1) begin
						command_text.push_back(8'($urandom_range(32, 126)));
					end
				end
				7: add_text($sformatf("FREQ=%0d", $urandom_range(0, 999)));
				default: begin
					n = $urandom_range(1, 6);
					repeat (n) command_text.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if ($urandom_range(0, 4) == 0) begin
			command_text.push_back(CHAR_SEMI);
		end
		if ($urandom_range(0, 5) == 0) begin
			command_text.push_back(8'h00);
			n = $urandom_range(0, 4);
			repeat (n) command_text.push_back(8'($urandom_range(0, 255)));
		end
		if (command_text.size() == 0) begin
			command_text.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: ready follows a pattern that changes every so often, from
	// always ready down to mostly stalled. On request it holds off for a long
	// stretch so that the result register and the queue fill and the block
	// pushes back on its input.
	initial begin : result_receiver
		int mode_left;
		int ready_pct;
		mode_left = 0;
		ready_pct = 100;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (holdoffs_done != holdoff_requests) begin
				holdoffs_done++;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(20, 200);
					case ($urandom_range(0, 3))
						0:       ready_pct = 100;
						1:       ready_pct = 50;
						2:       ready_pct = 85;
						default: ready_pct = 15;
					endcase
				end
				mode_left--;
				res_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
				@(posedge clk);
			end
		end
	end

	initial begin : cycle_watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("keyed_decimal_field_extractor_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		int phase_end;
		logic [7:0] limit_plan[RANDOM_PHASES];

		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.text_byte      <= '0;
		cmd_ch.end_of_command <= 1'b0;
		burst_left       = 0;
		steady_sender    = 1'b0;
		bytes_sent       = 0;
		commands_sent    = 0;
		limit_settings   = 1;
		cur_limit        = 255;
		holdoff_requests = 0;
		holdoffs_done    = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The limit must come out of reset at its top value.
		apb_access(1'b0, REG_CHANNEL_LIMIT, '0);

		// Directed commands at the reset limit: value extremes, saturation,
		// minus zero, misplaced and doubled minus, empty values, short and
		// shifted keys, first keyed segment wins, and zero terminators.
		send_command("CHANNEL=0");
		send_command("CHANNEL=255");
		send_command("CHANNEL=256");
		send_command("CHANNEL=99999");
		send_command("CHANNEL=-0");
		send_command("CHANNEL=-00");
		send_command("CHANNEL=-5");
		send_command("CHANNEL=1-2");
		send_command("CHANNEL=--1");
		send_command("CHANNEL=");
		send_command("CHANNEL=-");
		send_command("CHANNEL;CHANNEL=7");
		send_command("CHAN");
		send_command("FOO=1;CHANNEL=12;CHANNEL=99");
		send_command("CHANNEL=12;");
		send_command("channel=5");
		send_command("XCHANNEL=5");
		send_command(";;CHANNEL=008");
		send_command("C");
		// Content ends at a zero byte; what follows up to the last byte is dropped.
		add_text("CHANNEL=3");
		command_text.push_back(8'h00);
		send_command("CHANNEL=4");
		command_text.push_back(8'h00);
		send_command("CHANNEL=5");
		// A zero byte as the last byte ends a value just like a separator.
		add_text("CHANNEL=9");
		command_text.push_back(8'h00);
		send_text(1'b1);
		// A lone zero byte: nothing to find.
		command_text.push_back(8'h00);
		send_text(1'b1);
		// A high byte inside the value spoils it.
		add_text("CHANNEL=1");
		command_text.push_back(8'hFF);
		send_text(1'b1);
		settle();

		// A write to an unmapped index must leave the limit alone.
		apb_access(1'b1, REG_UNMAPPED, $urandom());
		apb_access(1'b0, REG_CHANNEL_LIMIT, '0);
		send_command("CHANNEL=200");
		settle();

		// Limit changes in the middle of a command apply from the next byte.
		add_text("CHANNEL=2");
		send_text(1'b0);
		settle();
		set_channel_limit(8'd10);
		send_command("5");
		send_command("CHANNEL=11");
		add_text("CHANNEL=0");
		send_text(1'b0);
		settle();
		set_channel_limit(8'd255);
		send_command("99");
		settle();

		// The smallest limit.
		set_channel_limit(8'd0);
		send_command("CHANNEL=0");
		send_command("CHANNEL=1");
		send_command("CHANNEL=-0");
		settle();

		// Random phases, each under its own limit, extremes included.
		limit_plan = '{8'd255, 8'd0, 8'($urandom_range(0, 255)), 8'd1,
			8'd9, 8'd100, 8'($urandom_range(0, 255)), 8'd255};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_channel_limit(limit_plan[p]);
			// In one phase the receiver stalls for a long time while the
			// sender streams without gaps, so the block must push back.
			steady_sender = (p == PRESSURE_PHASE);
			if (p == PRESSURE_PHASE) begin
				holdoff_requests++;
			end
			phase_end = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
			while (bytes_sent < phase_end) begin
				build_random_command();
				send_text(1'b1);
			end
			steady_sender = 1'b0;
			settle();
		end

		$display("Sent %0d command bytes in %0d commands under %0d limit settings,",
			bytes_sent, commands_sent, limit_settings);
		$display("with %0d absent, %0d valid and %0d invalid results and one long output stall.",
			absent_seen, valid_seen, invalid_seen);
		if (mismatches == 0) begin
			$display("keyed_decimal_field_extractor_tb: done, clean");
		end else begin
			$display("keyed_decimal_field_extractor_tb: done, errors");
		end
		$finish;
	end

endmodule
